[hdl/seconds_to_bcd_datetime_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the seconds-to-BCD date/time converter.
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SECONDS_TO_BCD_DATETIME_TOP_ASSERT_SVH
`define SECONDS_TO_BCD_DATETIME_TOP_ASSERT_SVH

// Overlapping implication.
`define S2BDT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Non-overlapping implication.
`define S2BDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/s2bdt_pkg.sv]
// ---------------------------------------------------------------------------
// s2bdt_pkg
// Constants, calendar tables and BCD helper for the date/time converter.
// ---------------------------------------------------------------------------
`default_nettype none

package s2bdt_pkg;

    // Years covered, starting at 2000
    localparam int YEAR_SPAN = 100;

    // Pipeline depth from accepted transaction to strobe
    localparam int PIPE_DEPTH = 11;

    // secs / 86400 == (secs >> 7) / 675; 675 done by reciprocal, 2^34 scale
    localparam int          DAY_SHIFT     = 34;
    localparam logic [24:0] DAY_RECIP     = 25'd25451658;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;

    // Four-year cycle: 1461 days, reciprocal at 2^27 scale
    localparam int          QUAD_SHIFT    = 27;
    localparam logic [16:0] QUAD_RECIP    = 17'd91867;
    localparam logic [10:0] QUAD_DAYS     = 11'd1461;

    // Divide by 60, reciprocal at 2^22 scale
    localparam int          SIXTY_SHIFT   = 22;
    localparam logic [16:0] SIXTY_RECIP   = 17'd69905;
    localparam logic [5:0]  SIXTY         = 6'd60;

    // Day offsets of years within a four-year cycle (first year is leap)
    localparam logic [10:0] YEAR1_START   = 11'd366;
    localparam logic [10:0] YEAR2_START   = 11'd731;
    localparam logic [10:0] YEAR3_START   = 11'd1096;

    // First day number beyond the covered span
    localparam logic [15:0] DAY_LIMIT     = 16'(365 * YEAR_SPAN + (YEAR_SPAN + 3) / 4);

    // Saturated date/time past the span
    localparam logic [6:0]  SAT_YEAR      = 7'(YEAR_SPAN - 1);
    localparam logic [6:0]  SAT_MONTH     = 7'd12;
    localparam logic [6:0]  SAT_DAY       = 7'd31;
    localparam logic [6:0]  SAT_HOUR      = 7'd23;
    localparam logic [6:0]  SAT_MINUTE    = 7'd59;
    localparam logic [6:0]  SAT_SECOND    = 7'd59;

    localparam logic [8:0] MONTH_START_COMMON [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [8:0] MONTH_START_LEAP [12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
        logic [8:0] v;
        if (leap) begin
            v = MONTH_START_LEAP[m];
        end else begin
            v = MONTH_START_COMMON[m];
        end
        return v;
    endfunction

    // Packed BCD of a value below 100; tens by *205 >> 11 (exact below 1029)
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

[hdl/seconds_to_bcd_datetime_top.sv]
// ---------------------------------------------------------------------------
// seconds_to_bcd_datetime_top
// Converts seconds since 2000-01-01 00:00:00 into a packed-BCD calendar
// date and time of day (century 20), with a flag past the covered span.
// ---------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  command   | start / busy           | i_seconds_since_2000
//  result    | o_strobe (one cycle)   | o_year/month/day/hour/minute/second_bcd,
//            |                        | o_out_of_range
//
// One transaction may be issued every cycle while busy is low. Each result
// passes through a chain of reciprocal multiply, remainder and correction
// steps for the divisions by 86400, 1461 and 60, each multiply followed by a
// register, and is strobed out of the last stage.
// busy is high while reset is held and clears on the first rising edge after
// release; the pipeline never stalls, and the receiver must take each result
// in the cycle it is strobed.
// Synchronous reset clears the valid bits; data registers are not reset.
//
`default_nettype none

module seconds_to_bcd_datetime_top
    import s2bdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_seconds_since_2000,
    output logic        o_strobe,
    output logic [7:0]  o_year_bcd,
    output logic [4:0]  o_month_bcd,
    output logic [5:0]  o_day_bcd,
    output logic [5:0]  o_hour_bcd,
    output logic [6:0]  o_minute_bcd,
    output logic [6:0]  o_second_bcd,
    output logic        o_out_of_range
);

    // ---------------- control ----------------
    logic                  r_busy;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  n_accept;

    assign busy     = r_busy;
    assign n_accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[PIPE_DEPTH-2:0], n_accept};
        end
    end

    // ---------------- stage 1: capture ----------------
    logic [31:0] r1_secs;

    // ---------------- stage 2: day estimate ----------------
    logic [49:0] n2_prod;
    logic [31:0] r2_secs;
    logic [15:0] r2_day0;

    assign n2_prod = 50'(r1_secs[31:7]) * 50'(DAY_RECIP);

    // ---------------- stage 3: seconds remainder ----------------
    logic [32:0] n3_rem;
    logic [15:0] r3_day0;
    logic [17:0] r3_rem;

    assign n3_rem = 33'(r2_secs) - 33'(r2_day0) * 33'(SECS_PER_DAY);

    // ---------------- stage 4: day correction ----------------
    logic [15:0] n4_days;
    logic [16:0] n4_sod;
    logic [15:0] r4_days;
    logic [16:0] r4_sod;
    logic        r4_oor;

    always_comb begin
        if (r3_rem >= 18'(SECS_PER_DAY)) begin
            n4_days = r3_day0 + 16'd1;
            n4_sod  = 17'(r3_rem - 18'(SECS_PER_DAY));
        end else begin
            n4_days = r3_day0;
            n4_sod  = r3_rem[16:0];
        end
    end

    // ---------------- stage 5: four-year and minute estimates ----------------
    logic [32:0] n5_qprod;
    logic [33:0] n5_mprod;
    logic [15:0] r5_days;
    logic [16:0] r5_sod;
    logic [5:0]  r5_quad0;
    logic [10:0] r5_min0;
    logic        r5_oor;

    assign n5_qprod = 33'(r4_days) * 33'(QUAD_RECIP);
    assign n5_mprod = 34'(r4_sod) * 34'(SIXTY_RECIP);

    // ---------------- stage 6: remainders ----------------
    logic [16:0] n6_qrem;
    logic [16:0] n6_srem;
    logic [5:0]  r6_quad0;
    logic [11:0] r6_qrem;
    logic [10:0] r6_min0;
    logic [6:0]  r6_srem;
    logic        r6_oor;

    assign n6_qrem = 17'(r5_days) - 17'(r5_quad0) * 17'(QUAD_DAYS);
    assign n6_srem = r5_sod - 17'(r5_min0) * 17'(SIXTY);

    // ---------------- stage 7: corrections ----------------
    logic [5:0]  n7_quad;
    logic [10:0] n7_dquad;
    logic [10:0] n7_mod;
    logic [5:0]  n7_sec;
    logic [5:0]  r7_quad;
    logic [10:0] r7_dquad;
    logic [10:0] r7_mod;
    logic [5:0]  r7_sec;
    logic        r7_oor;

    always_comb begin
        if (r6_qrem >= 12'(QUAD_DAYS)) begin
            n7_quad  = r6_quad0 + 6'd1;
            n7_dquad = 11'(r6_qrem - 12'(QUAD_DAYS));
        end else begin
            n7_quad  = r6_quad0;
            n7_dquad = r6_qrem[10:0];
        end
        if (r6_srem >= 7'(SIXTY)) begin
            n7_mod = r6_min0 + 11'd1;
            n7_sec = 6'(r6_srem - 7'(SIXTY));
        end else begin
            n7_mod = r6_min0;
            n7_sec = r6_srem[5:0];
        end
    end

    // ---------------- stage 8: year in cycle, hour estimate ----------------
    logic [1:0]  n8_yq;
    logic [10:0] n8_doy;
    logic [27:0] n8_hprod;
    logic [7:0]  r8_year;
    logic        r8_leap;
    logic [8:0]  r8_doy;
    logic [10:0] r8_mod;
    logic [4:0]  r8_hour0;
    logic [5:0]  r8_sec;
    logic        r8_oor;

    always_comb begin
        priority if (r7_dquad < YEAR1_START) begin
            n8_yq  = 2'd0;
            n8_doy = r7_dquad;
        end else if (r7_dquad < YEAR2_START) begin
            n8_yq  = 2'd1;
            n8_doy = r7_dquad - YEAR1_START;
        end else if (r7_dquad < YEAR3_START) begin
            n8_yq  = 2'd2;
            n8_doy = r7_dquad - YEAR2_START;
        end else begin
            n8_yq  = 2'd3;
            n8_doy = r7_dquad - YEAR3_START;
        end
    end

    assign n8_hprod = 28'(r7_mod) * 28'(SIXTY_RECIP);

    // ---------------- stage 9: month search, minute remainder ----------------
    logic [3:0]  n9_month;
    logic [10:0] n9_mrem;
    logic [7:0]  r9_year;
    logic        r9_leap;
    logic [8:0]  r9_doy;
    logic [3:0]  r9_month;
    logic [4:0]  r9_hour0;
    logic [6:0]  r9_mrem;
    logic [5:0]  r9_sec;
    logic        r9_oor;

    // later months win; compares are independent
    always_comb begin
        n9_month = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (r8_doy >= month_start(r8_leap, 4'(m))) begin
                n9_month = 4'(m);
            end
        end
    end

    assign n9_mrem = r8_mod - 11'(r8_hour0) * 11'(SIXTY);

    // ---------------- stage 10: day of month, hour correction ----------------
    logic [4:0]  n10_hour;
    logic [5:0]  n10_min;
    logic [8:0]  n10_mday;
    logic [7:0]  r10_year;
    logic [3:0]  r10_month;
    logic [4:0]  r10_mday;
    logic [4:0]  r10_hour;
    logic [5:0]  r10_min;
    logic [5:0]  r10_sec;
    logic        r10_oor;

    always_comb begin
        if (r9_mrem >= 7'(SIXTY)) begin
            n10_hour = r9_hour0 + 5'd1;
            n10_min  = 6'(r9_mrem - 7'(SIXTY));
        end else begin
            n10_hour = r9_hour0;
            n10_min  = r9_mrem[5:0];
        end
    end

    assign n10_mday = r9_doy - month_start(r9_leap, r9_month) + 9'd1;

    // ---------------- stage 11: BCD and saturation ----------------
    logic [7:0] n11_year;
    logic [7:0] n11_month;
    logic [7:0] n11_day;
    logic [7:0] n11_hour;
    logic [7:0] n11_min;
    logic [7:0] n11_sec;
    logic [7:0] r11_year;
    logic [4:0] r11_month;
    logic [5:0] r11_day;
    logic [5:0] r11_hour;
    logic [6:0] r11_min;
    logic [6:0] r11_sec;
    logic       r11_oor;

    always_comb begin
        if (r10_oor) begin
            n11_year  = to_bcd(SAT_YEAR);
            n11_month = to_bcd(SAT_MONTH);
            n11_day   = to_bcd(SAT_DAY);
            n11_hour  = to_bcd(SAT_HOUR);
            n11_min   = to_bcd(SAT_MINUTE);
            n11_sec   = to_bcd(SAT_SECOND);
        end else begin
            n11_year  = to_bcd(r10_year[6:0]);
            n11_month = to_bcd(7'(r10_month) + 7'd1);
            n11_day   = to_bcd(7'(r10_mday));
            n11_hour  = to_bcd(7'(r10_hour));
            n11_min   = to_bcd(7'(r10_min));
            n11_sec   = to_bcd(7'(r10_sec));
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r1_secs   <= i_seconds_since_2000;

        r2_secs   <= r1_secs;
        r2_day0   <= n2_prod[DAY_SHIFT+15:DAY_SHIFT];

        r3_day0   <= r2_day0;
        r3_rem    <= n3_rem[17:0];

        r4_days   <= n4_days;
        r4_sod    <= n4_sod;
        r4_oor    <= n4_days >= DAY_LIMIT;

        r5_days   <= r4_days;
        r5_sod    <= r4_sod;
        r5_quad0  <= n5_qprod[QUAD_SHIFT+5:QUAD_SHIFT];
        r5_min0   <= n5_mprod[SIXTY_SHIFT+10:SIXTY_SHIFT];
        r5_oor    <= r4_oor;

        r6_quad0  <= r5_quad0;
        r6_qrem   <= n6_qrem[11:0];
        r6_min0   <= r5_min0;
        r6_srem   <= n6_srem[6:0];
        r6_oor    <= r5_oor;

        r7_quad   <= n7_quad;
        r7_dquad  <= n7_dquad;
        r7_mod    <= n7_mod;
        r7_sec    <= n7_sec;
        r7_oor    <= r6_oor;

        r8_year   <= {r7_quad, n8_yq};
        r8_leap   <= n8_yq == 2'd0;
        r8_doy    <= n8_doy[8:0];
        r8_mod    <= r7_mod;
        r8_hour0  <= n8_hprod[SIXTY_SHIFT+4:SIXTY_SHIFT];
        r8_sec    <= r7_sec;
        r8_oor    <= r7_oor;

        r9_year   <= r8_year;
        r9_leap   <= r8_leap;
        r9_doy    <= r8_doy;
        r9_month  <= n9_month;
        r9_hour0  <= r8_hour0;
        r9_mrem   <= n9_mrem[6:0];
        r9_sec    <= r8_sec;
        r9_oor    <= r8_oor;

        r10_year  <= r9_year;
        r10_month <= r9_month;
        r10_mday  <= n10_mday[4:0];
        r10_hour  <= n10_hour;
        r10_min   <= n10_min;
        r10_sec   <= r9_sec;
        r10_oor   <= r9_oor;

        r11_year  <= n11_year;
        r11_month <= n11_month[4:0];
        r11_day   <= n11_day[5:0];
        r11_hour  <= n11_hour[5:0];
        r11_min   <= n11_min[6:0];
        r11_sec   <= n11_sec[6:0];
        r11_oor   <= r10_oor;
    end

    // ---------------- outputs ----------------
    assign o_strobe       = r_vld[PIPE_DEPTH-1];
    assign o_year_bcd     = r11_year;
    assign o_month_bcd    = r11_month;
    assign o_day_bcd      = r11_day;
    assign o_hour_bcd     = r11_hour;
    assign o_minute_bcd   = r11_min;
    assign o_second_bcd   = r11_sec;
    assign o_out_of_range = r11_oor;

endmodule

`default_nettype wire

[hdl/s2bdt_checker.sv]
// ---------------------------------------------------------------------------
// s2bdt_checker
// Port-level checks for the date/time converter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "seconds_to_bcd_datetime_top_assert.svh"

module s2bdt_checker
    import s2bdt_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic [7:0] o_year_bcd,
    input wire logic [4:0] o_month_bcd,
    input wire logic [5:0] o_day_bcd,
    input wire logic [5:0] o_hour_bcd,
    input wire logic [6:0] o_minute_bcd,
    input wire logic [6:0] o_second_bcd,
    input wire logic       o_out_of_range
);

    // every accepted transaction yields a strobe at the end of the pipeline
    `S2BDT_ASSERT_IMPL(a_latency, start && !busy, ##PIPE_DEPTH o_strobe, "result missing")

    // no strobe without a transaction accepted earlier at the input
    `S2BDT_ASSERT_IMPL(a_no_spurious, o_strobe, $past(start && !busy, PIPE_DEPTH), "spurious result")

    // past the span the month, day and time of day saturate
    `S2BDT_ASSERT_IMPL(a_saturate, o_strobe && o_out_of_range, o_month_bcd == 5'h12 && o_day_bcd == 6'h31 && o_hour_bcd == 6'h23 && o_minute_bcd == 7'h59 && o_second_bcd == 7'h59, "bad saturation")

    // in range, month/day nonzero, hour <= 23, year/min/sec units <= 9
    `S2BDT_ASSERT_IMPL(a_bcd_legal, o_strobe && !o_out_of_range, o_month_bcd != 5'h0 && o_day_bcd != 6'h0 && o_hour_bcd <= 6'h23 && o_minute_bcd[3:0] <= 4'd9 && o_second_bcd[3:0] <= 4'd9 && o_year_bcd[3:0] <= 4'd9, "illegal BCD")

    // busy clears the cycle after reset is released
    `S2BDT_ASSERT_NEXT(a_busy_clear, 1'b1, !busy, "busy stuck")

endmodule

bind seconds_to_bcd_datetime_top s2bdt_checker u_s2bdt_checker (.*);

`default_nettype wire

[sim/tb_seconds_to_bcd_datetime_top.sv]
// ----------------------------------------------------------------------------
// tb_seconds_to_bcd_datetime_top
// Self-checking bench for the seconds-to-BCD calendar converter. A directed
// table of timestamps runs first: epoch, day, month and year edges, leap days,
// the last covered second and the saturated range above it. About 1500 random
// timestamps follow, weighted towards day, month and year boundaries. Every
// result is checked against a typed row or an independent calendar predictor.
// ----------------------------------------------------------------------------

module tb_seconds_to_bcd_datetime_top;
    import s2bdt_pkg::*;

    // Result fields at the port widths, in port order.
    typedef struct packed {
        logic [7:0] year;
        logic [4:0] month;
        logic [5:0] mday;
        logic [5:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic       out_of_range;
    } t_datetime;

    // One directed row. When typed is set, want is the value written by hand.
    // Otherwise the predictor supplies the expectation.
    typedef struct packed {
        logic [31:0] secs;
        bit          typed;
        t_datetime   want;
    } t_probe;

    localparam int unsigned SECS_IN_DAY    = 86400;
    localparam int          N_PROBES       = 24;
    localparam int          N_RANDOM       = 1500;
    localparam int          NO_IDLE_FROM   = 400;  // long stretch with back-to-back commands
    localparam int          NO_IDLE_TO     = 700;
    localparam int          DRAIN_AT       = 1000; // sender holds off until all results are in
    localparam int          WATCHDOG_LIMIT = 500;

    localparam t_datetime LAST_COVERED =
        '{8'h99, 5'h12, 6'h31, 6'h23, 7'h59, 7'h59, 1'b0};
    localparam t_datetime SATURATED =
        '{8'h99, 5'h12, 6'h31, 6'h23, 7'h59, 7'h59, 1'b1};

    // Directed table. Rows with a typed result can be read off the calendar
    // directly. The remaining rows rely on the predictor.
    t_probe directed_probes [N_PROBES] = '{
        '{32'd0,          1'b1, '{8'h00, 5'h01, 6'h01, 6'h00, 7'h00, 7'h00, 1'b0}},
        '{32'd45296,      1'b1, '{8'h00, 5'h01, 6'h01, 6'h12, 7'h34, 7'h56, 1'b0}},
        '{32'd86399,      1'b1, '{8'h00, 5'h01, 6'h01, 6'h23, 7'h59, 7'h59, 1'b0}},
        '{32'd86400,      1'b1, '{8'h00, 5'h01, 6'h02, 6'h00, 7'h00, 7'h00, 1'b0}},
        '{32'd5097600,    1'b1, '{8'h00, 5'h02, 6'h29, 6'h00, 7'h00, 7'h00, 1'b0}},
        '{32'd5184000,    1'b1, '{8'h00, 5'h03, 6'h01, 6'h00, 7'h00, 7'h00, 1'b0}},
        '{32'd31622399,   1'b1, '{8'h00, 5'h12, 6'h31, 6'h23, 7'h59, 7'h59, 1'b0}},
        '{32'd31622400,   1'b1, '{8'h01, 5'h01, 6'h01, 6'h00, 7'h00, 7'h00, 1'b0}},
        '{32'd36719999,   1'b0, '0},   // 2001-02-28, common year
        '{32'd36720000,   1'b0, '0},   // 2001-03-01
        '{32'd63158400,   1'b0, '0},   // third year of the four-year cycle
        '{32'd94694400,   1'b0, '0},   // fourth year of the cycle
        '{32'd126230399,  1'b0, '0},   // last second of the first cycle
        '{32'd126230400,  1'b0, '0},   // 2004, leap again
        '{32'd3034627200, 1'b0, '0},   // 2096-02-29
        '{32'd3124223999, 1'b1, '{8'h98, 5'h12, 6'h31, 6'h23, 7'h59, 7'h59, 1'b0}},
        '{32'd3124224000, 1'b1, '{8'h99, 5'h01, 6'h01, 6'h00, 7'h00, 7'h00, 1'b0}},
        '{32'd3129321600, 1'b0, '0},   // 2099-03-01, last year is common
        '{32'd3155759999, 1'b1, LAST_COVERED},
        '{32'd3155760000, 1'b1, SATURATED},
        '{32'hFFFF_FFFF,  1'b1, SATURATED},
        '{32'h7FFF_FFFF,  1'b0, '0},
        '{32'h8000_0000,  1'b0, '0},
        '{32'hAAAA_AAAA,  1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_seconds_since_2000 = 32'd0;
    logic        o_strobe;
    logic [7:0]  o_year_bcd;
    logic [4:0]  o_month_bcd;
    logic [5:0]  o_day_bcd;
    logic [5:0]  o_hour_bcd;
    logic [6:0]  o_minute_bcd;
    logic [6:0]  o_second_bcd;
    logic        o_out_of_range;

    // Expected conversions, oldest first.
    t_datetime pending_datetimes [$];

    int mismatches   = 0;
    int n_accepted   = 0;
    int n_checked    = 0;
    int n_saturated  = 0;
    int stall_cycles = 0;

    seconds_to_bcd_datetime_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_seconds_since_2000 (i_seconds_since_2000),
        .o_strobe             (o_strobe),
        .o_year_bcd           (o_year_bcd),
        .o_month_bcd          (o_month_bcd),
        .o_day_bcd            (o_day_bcd),
        .o_hour_bcd           (o_hour_bcd),
        .o_minute_bcd         (o_minute_bcd),
        .o_second_bcd         (o_second_bcd),
        .o_out_of_range       (o_out_of_range)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------

    // Day number of 1 January of year y. Every fourth year from 2000 is leap.
    function automatic int unsigned first_day_of_year(input int unsigned y);
        return 365 * y + (y + 3) / 4;
    endfunction

    // Days in the year before month m (0 = January).
    function automatic int unsigned days_before_month(input bit leap, input int unsigned m);
        int unsigned total;
        total = 0;
        for (int unsigned k = 0; k < m; k++) begin
            case (k)
                1:       total += leap ? 29 : 28;
                3, 5, 8, 10: total += 30;
                default: total += 31;
            endcase
        end
        return total;
    endfunction

    function automatic logic [7:0] pack_bcd(input int unsigned v);
        logic [3:0] tens;
        logic [3:0] ones;
        tens = 4'((v / 10) % 10);
        ones = 4'(v % 10);
        return {tens, ones};
    endfunction

    function automatic t_datetime calendar_of(input logic [31:0] secs);
        t_datetime   r;
        int unsigned day_num;
        int unsigned tod;
        int unsigned yr;
        int unsigned mo;
        int unsigned in_year;
        bit          leap;
        day_num = secs / SECS_IN_DAY;
        tod     = secs % SECS_IN_DAY;
        // Past the covered span the converter pins to its last second.
        if (day_num >= first_day_of_year(YEAR_SPAN)) begin
            r              = LAST_COVERED;
            r.year         = pack_bcd(YEAR_SPAN - 1);
            r.out_of_range = 1'b1;
            return r;
        end
        yr = 0;
        for (int unsigned y = 1; y < YEAR_SPAN; y++) begin
            if (day_num >= first_day_of_year(y)) begin
                yr = y;
            end
        end
        in_year = day_num - first_day_of_year(yr);
        leap    = (yr % 4 == 0);
        mo      = 0;
        for (int unsigned m = 1; m < 12; m++) begin
            if (in_year >= days_before_month(leap, m)) begin
                mo = m;
            end
        end
        r.year         = pack_bcd(yr);
        r.month        = 5'(pack_bcd(mo + 1));
        r.mday         = 6'(pack_bcd(in_year - days_before_month(leap, mo) + 1));
        r.hour         = 6'(pack_bcd(tod / 3600));
        r.minute       = 7'(pack_bcd((tod % 3600) / 60));
        r.second       = 7'(pack_bcd(tod % 60));
        r.out_of_range = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Random timestamp, weighted towards edges where the carries happen.
    function automatic logic [31:0] pick_timestamp();
        int unsigned pick;
        int unsigned yr;
        int unsigned day_num;
        int unsigned base;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return $urandom_range(32'd3155759999, 32'd0);
        end else if (pick < 60) begin
            // Either side of midnight, the hour and minute edges, or any second of that day.
            base = $urandom_range(36524) * SECS_IN_DAY;
            case ($urandom_range(3))
                0:       return base;
                1:       return base + SECS_IN_DAY - 1;
                2:       return base + $urandom_range(23) * 3600 + $urandom_range(1) * 3599;
                default: return base + $urandom_range(86399);
            endcase
        end else if (pick < 85) begin
            // Start of a random month, the last second before it, or any second of its first day.
            yr      = $urandom_range(YEAR_SPAN - 1);
            day_num = first_day_of_year(yr)
                      + days_before_month(yr % 4 == 0, $urandom_range(11));
            base    = day_num * SECS_IN_DAY;
            case ($urandom_range(2))
                0:       return base;
                1:       return (base == 0) ? base : base - 1;
                default: return base + $urandom_range(86399);
            endcase
        end else if (pick < 93) begin
            return $urandom_range(32'hFFFF_FFFF, 32'd3155760000);
        end else begin
            return $urandom;
        end
    endfunction

    // Random gap with start low and junk data on the port. Pausing before
    // one item in seven leaves the sender idle in roughly a fifth of all cycles.
    task automatic maybe_pause(input bit allowed);
        int gap;
        if (allowed && $urandom_range(99) < 14) begin
            gap = $urandom_range(3, 1);
            @(negedge i_clk);
            start                <= 1'b0;
            i_seconds_since_2000 <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Present one command and hold it until it is taken. busy only moves on a
    // rising edge, so the value seen at the falling edge decides acceptance at
    // the next rising edge. The expectation is queued there, before a strobe
    // could pop it.
    task automatic issue_timestamp(input logic [31:0] secs, input t_datetime want);
        bit taken;
        taken = 1'b0;
        @(negedge i_clk);
        start                <= 1'b1;
        i_seconds_since_2000 <= secs;
        while (!taken) begin
            if (!busy) begin
                taken = 1'b1;
                pending_datetimes.push_back(want);
            end
            @(posedge i_clk);
            if (!taken) begin
                @(negedge i_clk);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input t_datetime want,
                                   input t_datetime got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at %0t: expected %h-%h-%h %h:%h:%h oor=%b, got %h-%h-%h %h:%h:%h oor=%b",
                     what, $realtime,
                     want.year, want.month, want.mday, want.hour, want.minute,
                     want.second, want.out_of_range,
                     got.year, got.month, got.mday, got.hour, got.minute,
                     got.second, got.out_of_range);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------------
    // Everything is sampled at the rising edge, before the design updates.
    // The watchdog only counts cycles in which neither channel moves.
    always @(posedge i_clk) begin : result_check
        t_datetime got;
        t_datetime want;
        bit        progress;
        progress = 1'b0;
        if (i_rst_n && start && !busy) begin
            n_accepted++;
            progress = 1'b1;
        end
        if (i_rst_n && o_strobe) begin
            progress = 1'b1;
            got = '{o_year_bcd, o_month_bcd, o_day_bcd, o_hour_bcd,
                    o_minute_bcd, o_second_bcd, o_out_of_range};
            if (pending_datetimes.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_datetimes.pop_front();
                n_checked++;
                if (want.out_of_range) begin
                    n_saturated++;
                end
                if (got !== want) begin
                    report_mismatch("result mismatch", want, got);
                end
            end
        end
        if (progress) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stall_cycles, pending_datetimes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] secs;
        t_datetime   want;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, with random gaps between them.
        for (int i = 0; i < N_PROBES; i++) begin
            maybe_pause(1'b1);
            if (directed_probes[i].typed) begin
                want = directed_probes[i].want;
            end else begin
                want = calendar_of(directed_probes[i].secs);
            end
            issue_timestamp(directed_probes[i].secs, want);
        end

        // Random timestamps. One stretch runs back to back. Part way through,
        // the sender stops until the pipeline has drained completely.
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == DRAIN_AT) begin
                @(negedge i_clk);
                start <= 1'b0;
                while (pending_datetimes.size() != 0) @(posedge i_clk);
            end
            maybe_pause(k < NO_IDLE_FROM || k >= NO_IDLE_TO);
            secs = pick_timestamp();
            issue_timestamp(secs, calendar_of(secs));
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_datetimes.size() != 0) @(posedge i_clk);
        // Keep clocking past the pipeline depth to catch any stray strobe.
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        $display("Sent %0d timestamps (%0d directed, %0d random), checked %0d results,",
                 n_accepted, N_PROBES, N_RANDOM, n_checked);
        $display("%0d of them past 2099; result mismatches: %0d.", n_saturated, mismatches);
        if (mismatches == 0 && pending_datetimes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
